// ----- rtl/fingerprint_nearest_match_assert.svh -----
// assertion macros for the fingerprint nearest-match block
`ifndef FINGERPRINT_NEAREST_MATCH_ASSERT_SVH
`define FINGERPRINT_NEAREST_MATCH_ASSERT_SVH

// same-cycle implication, off during reset
`define FNM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("fnm check failed: same-cycle implication");

// next-cycle implication, off during reset
`define FNM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("fnm check failed: next-cycle implication");

`endif

// ----- rtl/fnm_pkg.sv -----
// shared constants and types of the fingerprint nearest-match block
package fnm_pkg;

    localparam int TABLE_ENTRIES = 8;
    localparam int AP_COUNT      = 4;

    localparam int STR_W   = 12;
    localparam int POS_W   = 16;
    localparam int IDX_W   = 3;
    localparam int MATCH_W = 3;
    localparam int CFG_W   = 4;
    // abs difference fits STR_W bits, four of them need two more
    localparam int DIST_W  = STR_W + 2;

    localparam int SLOT_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int LEVELS = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int TREE_W = 1 << LEVELS;

    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic [ADDR_W-3:0] REG_ENTRIES_IN_USE = '0;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } t_op;

    typedef logic signed [STR_W-1:0] t_str;
    typedef logic signed [POS_W-1:0] t_pos;

    typedef struct packed {
        logic              vld;
        logic [DIST_W-1:0] dsum;
        logic [SLOT_W-1:0] slot;
        t_pos              pos_x;
        t_pos              pos_y;
    } t_cand;

endpackage

// ----- rtl/fingerprint_nearest_match.sv -----
// top level of the fingerprint nearest-match block
// A load beat writes one table slot in the cycle it is taken; loads flow one per
// cycle while no query is in flight. A query beat passes through the query
// register, which also holds the pick of the dropped strength, a lane register
// per table slot that forms its distance, the levels of the registered minimum
// tree and the output register. The block takes no new beat from the query
// until its result beat is taken. The table sits in flip-flops with no reset;
// searching a slot that was never loaded gives undefined fields.
`include "fingerprint_nearest_match_assert.svh"

module fingerprint_nearest_match import fnm_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_operation,
    input  logic [IDX_W-1:0]    i_entry_index,
    input  logic signed [POS_W-1:0] i_ref_pos_x,
    input  logic signed [POS_W-1:0] i_ref_pos_y,
    input  logic signed [STR_W-1:0] i_strength_a,
    input  logic signed [STR_W-1:0] i_strength_b,
    input  logic signed [STR_W-1:0] i_strength_c,
    input  logic signed [STR_W-1:0] i_strength_d,
    output logic                o_valid,
    input  logic                i_stall,
    output logic signed [POS_W-1:0] o_est_x,
    output logic signed [POS_W-1:0] o_est_y,
    output logic [MATCH_W-1:0]  o_match_slot,
    output logic                o_found,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready
);

    logic [CFG_W-1:0]    r_entries;
    logic                r_busy;
    logic                r_q_vld;
    logic                r_lane_vld;
    logic                r_out_vld;
    t_str                r_q_str [AP_COUNT];
    logic [AP_COUNT-1:0] r_q_keep;
    t_str                r_tab_str [TABLE_ENTRIES][AP_COUNT];
    t_pos                r_tab_x [TABLE_ENTRIES];
    t_pos                r_tab_y [TABLE_ENTRIES];
    t_pos                r_out_x;
    t_pos                r_out_y;
    logic [MATCH_W-1:0]  r_out_slot;
    logic                r_out_found;

    t_str                w_in_str [AP_COUNT];
    logic [AP_COUNT-1:0] n_keep;
    logic                w_in_acc;
    logic                w_out_acc;
    logic                w_cfg_wr;
    t_cand               w_lane [TABLE_ENTRIES];
    logic                w_root_vld;
    t_cand               w_root;
    logic [MATCH_W+SLOT_W-1:0] w_slot_ext;

    assign w_in_str[0] = i_strength_a;
    assign w_in_str[1] = i_strength_b;
    assign w_in_str[2] = i_strength_c;
    assign w_in_str[3] = i_strength_d;

    assign w_in_acc  = i_valid && !o_stall;
    assign w_out_acc = o_valid && !i_stall;

    // configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready
                   && (paddr[ADDR_W-1:2] == REG_ENTRIES_IN_USE);

    always_comb begin
        prdata = '0;
        if (paddr[ADDR_W-1:2] == REG_ENTRIES_IN_USE) begin
            prdata = DATA_W'(r_entries);
        end
    end

    // weakest strength is dropped, lowest index on a tie
    always_comb begin
        logic [1:0] low_ap;
        low_ap = '0;
        for (int k = 1; k < AP_COUNT; k++) begin
            if (w_in_str[k] < w_in_str[low_ap]) begin
                low_ap = 2'(k);
            end
        end
        n_keep = ~(AP_COUNT'(1) << low_ap);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries  <= '0;
            r_busy     <= 1'b0;
            r_q_vld    <= 1'b0;
            r_lane_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (w_cfg_wr) begin
                r_entries <= pwdata[CFG_W-1:0];
            end
            r_q_vld    <= w_in_acc && (i_operation == OP_QUERY);
            r_lane_vld <= r_q_vld;
            if (w_in_acc && (i_operation == OP_QUERY)) begin
                r_busy <= 1'b1;
            end else if (w_out_acc) begin
                r_busy <= 1'b0;
            end
            if (w_root_vld) begin
                r_out_vld <= 1'b1;
            end else if (w_out_acc) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // table writes and query capture
    always_ff @(posedge i_clk) begin
        if (w_in_acc && (i_operation == OP_QUERY)) begin
            r_q_str  <= w_in_str;
            r_q_keep <= n_keep;
        end
        for (int j = 0; j < TABLE_ENTRIES; j++) begin
            if (w_in_acc && (i_operation == OP_LOAD) && (int'(i_entry_index) == j)) begin
                r_tab_str[j] <= w_in_str;
                r_tab_x[j]   <= i_ref_pos_x;
                r_tab_y[j]   <= i_ref_pos_y;
            end
        end
    end

    for (genvar j = 0; j < TABLE_ENTRIES; j++) begin : g_lane
        fnm_lane u_lane (
            .i_clk     (i_clk),
            .i_active  (j < int'(r_entries)),
            .i_slot    (SLOT_W'(j)),
            .i_ref_str (r_tab_str[j]),
            .i_ref_x   (r_tab_x[j]),
            .i_ref_y   (r_tab_y[j]),
            .i_qry_str (r_q_str),
            .i_keep    (r_q_keep),
            .o_cand    (w_lane[j])
        );
    end

    fnm_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_lane_vld),
        .i_cand  (w_lane),
        .o_vld   (w_root_vld),
        .o_cand  (w_root)
    );

    assign w_slot_ext = {MATCH_W'(0), w_root.slot};

    // empty search gives zero fields with found low
    always_ff @(posedge i_clk) begin
        if (w_root_vld) begin
            r_out_found <= w_root.vld;
            r_out_x     <= w_root.vld ? w_root.pos_x : '0;
            r_out_y     <= w_root.vld ? w_root.pos_y : '0;
            r_out_slot  <= w_root.vld ? w_slot_ext[MATCH_W-1:0] : '0;
        end
    end

    assign o_stall      = r_busy;
    assign o_valid      = r_out_vld;
    assign o_est_x      = r_out_x;
    assign o_est_y      = r_out_y;
    assign o_match_slot = r_out_slot;
    assign o_found      = r_out_found;

    `FNM_ASSERT_IMP(a_out_needs_busy, i_clk, i_rst_n, o_valid, r_busy)
    `FNM_ASSERT_IMP(a_root_only_when_free, i_clk, i_rst_n, w_root_vld, r_busy && !r_out_vld)
    `FNM_ASSERT_NXT(a_query_not_at_once, i_clk, i_rst_n,
                    w_in_acc && (i_operation == OP_QUERY), !o_valid && o_stall)
    `FNM_ASSERT_IMP(a_found_in_range, i_clk, i_rst_n, o_valid && o_found,
                    int'(o_match_slot) < int'(r_entries))

endmodule

// ----- rtl/fnm_lane.sv -----
// one distance lane: manhattan distance of the query to one table entry
module fnm_lane import fnm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_active,
    input  logic [SLOT_W-1:0] i_slot,
    input  t_str              i_ref_str [AP_COUNT],
    input  t_pos              i_ref_x,
    input  t_pos              i_ref_y,
    input  t_str              i_qry_str [AP_COUNT],
    input  logic [AP_COUNT-1:0] i_keep,
    output t_cand             o_cand
);

    t_cand             r_cand;
    logic [DIST_W-1:0] n_dist;

    always_comb begin
        logic signed [STR_W:0] diff;
        logic [STR_W:0]        mag;
        n_dist = '0;
        for (int k = 0; k < AP_COUNT; k++) begin
            diff = $signed({i_ref_str[k][STR_W-1], i_ref_str[k]})
                 - $signed({i_qry_str[k][STR_W-1], i_qry_str[k]});
            mag  = diff[STR_W] ? (STR_W+1)'(0) - diff : diff;
            if (i_keep[k]) begin
                n_dist = n_dist + DIST_W'(mag[STR_W-1:0]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cand.vld   <= i_active;
        r_cand.dsum  <= n_dist;
        r_cand.slot  <= i_slot;
        r_cand.pos_x <= i_ref_x;
        r_cand.pos_y <= i_ref_y;
    end

    assign o_cand = r_cand;

endmodule

// ----- rtl/fnm_merge.sv -----
// registered minimum tree over the lane results, earliest slot wins a tie
module fnm_merge import fnm_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_vld,
    input  t_cand i_cand [TABLE_ENTRIES],
    output logic  o_vld,
    output t_cand o_cand
);

    // heap layout: node 1 is the root, nodes from TREE_W up are the leaves
    t_cand             w_node [1:2*TREE_W-1];
    t_cand             r_node [1:TREE_W-1];
    logic [LEVELS-1:0] r_sr;

    function automatic t_cand pick(input t_cand lo, input t_cand hi);
        if (lo.vld && (!hi.vld || lo.dsum <= hi.dsum)) begin
            return lo;
        end
        return hi;
    endfunction

    always_comb begin
        for (int i = 1; i < TREE_W; i++) begin
            w_node[i] = r_node[i];
        end
        for (int j = 0; j < TREE_W; j++) begin
            if (j < TABLE_ENTRIES) begin
                w_node[TREE_W+j] = i_cand[j];
            end else begin
                w_node[TREE_W+j] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 1; i < TREE_W; i++) begin
            r_node[i] <= pick(w_node[2*i], w_node[2*i+1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sr <= '0;
        end else begin
            r_sr <= LEVELS'({r_sr, i_vld});
        end
    end

    assign o_vld  = r_sr[LEVELS-1];
    assign o_cand = r_node[1];

endmodule

// ----- tb/sv/fingerprint_nearest_match_tb.sv -----
// testbench for the fingerprint nearest-match block: directed table, then paced random beats
`timescale 1ns / 1ps

module fingerprint_nearest_match_tb import fnm_pkg::*;;

    localparam int LIMIT_CYCLES  = 400000;
    localparam int RANDOM_BEATS  = 1300;
    localparam int SETTLE_CYCLES = 12;
    localparam int MAX_PRINTS    = 40;

    typedef struct packed {
        t_op                     op;
        logic [IDX_W-1:0]        idx;
        t_pos                    x;
        t_pos                    y;
        logic [AP_COUNT-1:0][STR_W-1:0] s;
    } t_beat;

    typedef struct packed {
        t_pos               x;
        t_pos               y;
        logic [MATCH_W-1:0] slot;
        logic               found;
    } t_match;

    typedef enum {ROW_BEAT, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind        kind;
        logic [CFG_W-1:0] cfg;
        t_beat            b;
        bit               typed;
        t_match           want;
    } t_row;

    typedef enum {STALL_NONE, STALL_SPARSE, STALL_PATTERN, STALL_HEAVY} t_stall_mode;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    logic i_operation;
    logic [IDX_W-1:0] i_entry_index;
    logic signed [POS_W-1:0] i_ref_pos_x;
    logic signed [POS_W-1:0] i_ref_pos_y;
    logic signed [STR_W-1:0] i_strength_a;
    logic signed [STR_W-1:0] i_strength_b;
    logic signed [STR_W-1:0] i_strength_c;
    logic signed [STR_W-1:0] i_strength_d;
    logic o_valid;
    logic i_stall;
    logic signed [POS_W-1:0] o_est_x;
    logic signed [POS_W-1:0] o_est_y;
    logic [MATCH_W-1:0] o_match_slot;
    logic o_found;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic pready;

    fingerprint_nearest_match u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_operation   (i_operation),
        .i_entry_index (i_entry_index),
        .i_ref_pos_x   (i_ref_pos_x),
        .i_ref_pos_y   (i_ref_pos_y),
        .i_strength_a  (i_strength_a),
        .i_strength_b  (i_strength_b),
        .i_strength_c  (i_strength_c),
        .i_strength_d  (i_strength_d),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_est_x       (o_est_x),
        .o_est_y       (o_est_y),
        .o_match_slot  (o_match_slot),
        .o_found       (o_found),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // shadow of the fingerprint table and the search-length register
    t_str tbl_str [TABLE_ENTRIES][AP_COUNT];
    t_pos tbl_x [TABLE_ENTRIES];
    t_pos tbl_y [TABLE_ENTRIES];
    logic [CFG_W-1:0] entries_shadow;

    t_match pending_matches[$];
    t_row directed[$];
    int errors;
    int burst_left;
    int cycles;

    task automatic report_mismatch(string what, int got, int want);
        errors++;
        if (errors <= MAX_PRINTS)
            $display("mismatch %s: got %0d expected %0d", what, got, want);
    endtask

    function automatic void add_row(t_row r);
        directed.insert(directed.size(), r);
    endfunction

    function automatic t_str rand_str();
        case ($urandom_range(9))
            0: return t_str'(-2048);
            1: return t_str'(2047);
            2: return t_str'(0);
            default: return t_str'($urandom);
        endcase
    endfunction

    function automatic t_pos rand_pos();
        case ($urandom_range(7))
            0: return t_pos'(-32768);
            1: return t_pos'(32767);
            default: return t_pos'($urandom);
        endcase
    endfunction

    function automatic int searched_entries();
        return (entries_shadow > TABLE_ENTRIES) ? TABLE_ENTRIES : int'(entries_shadow);
    endfunction

    // nearest entry by manhattan distance over the three strongest access points
    function automatic t_match nearest_entry(t_beat b);
        int weakest;
        int sum;
        int best;
        int d;
        bit have;
        t_match m;
        weakest = 0;
        have = 1'b0;
        best = 0;
        m = '0;
        for (int k = 1; k < AP_COUNT; k++)
            if ($signed(b.s[k]) < $signed(b.s[weakest]))
                weakest = k;
        for (int i = 0; i < searched_entries(); i++) begin
            sum = 0;
            for (int k = 0; k < AP_COUNT; k++) begin
                if (k != weakest) begin
                    d = int'(tbl_str[i][k]) - int'($signed(b.s[k]));
                    sum += (d < 0) ? -d : d;
                end
            end
            // only a strictly smaller sum replaces, so the earliest slot wins a tie
            if (!have || sum < best) begin
                have = 1'b1;
                best = sum;
                m.x = tbl_x[i];
                m.y = tbl_y[i];
                m.slot = MATCH_W'(i);
                m.found = 1'b1;
            end
        end
        return m;
    endfunction

    task automatic send_beat(t_beat b, bit typed, t_match typed_want);
        t_match want_m;
        i_valid       <= 1'b1;
        i_operation   <= b.op;
        i_entry_index <= b.idx;
        i_ref_pos_x   <= b.x;
        i_ref_pos_y   <= b.y;
        i_strength_a  <= b.s[0];
        i_strength_b  <= b.s[1];
        i_strength_c  <= b.s[2];
        i_strength_d  <= b.s[3];
        do @(posedge i_clk); while (o_stall);
        if (b.op == OP_LOAD) begin
            for (int k = 0; k < AP_COUNT; k++)
                tbl_str[b.idx][k] = $signed(b.s[k]);
            tbl_x[b.idx] = b.x;
            tbl_y[b.idx] = b.y;
        end else begin
            want_m = typed ? typed_want : nearest_entry(b);
            pending_matches.insert(pending_matches.size(), want_m);
        end
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_matches.size() != 0);
    endtask

    task automatic pace();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            if ($urandom_range(80) == 0) begin
                drain_results();
            end else begin
                i_valid       <= 1'b0;
                i_operation   <= 1'($urandom);
                i_entry_index <= IDX_W'($urandom);
                i_ref_pos_x   <= t_pos'($urandom);
                i_ref_pos_y   <= t_pos'($urandom);
                i_strength_a  <= t_str'($urandom);
                i_strength_b  <= t_str'($urandom);
                i_strength_c  <= t_str'($urandom);
                i_strength_d  <= t_str'($urandom);
                repeat ($urandom_range(8, 1)) @(posedge i_clk);
            end
            burst_left = ($urandom_range(3) == 0) ? $urandom_range(100, 30) : $urandom_range(8);
        end
    endtask

    // register writes only once the block has gone quiet
    task automatic write_entries_in_use(logic [CFG_W-1:0] value);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_ENTRIES_IN_USE, 2'b00};
        pwdata  <= DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        entries_shadow = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== DATA_W'(value))
            report_mismatch("entries_in_use readback", int'(prdata), int'(value));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic t_row row_beat(t_op op, int idx, int x, int y, int a, int b, int c,
                                      int d);
        t_row r;
        r.kind  = ROW_BEAT;
        r.cfg   = '0;
        r.b.op  = op;
        r.b.idx = IDX_W'(idx);
        r.b.x   = t_pos'(x);
        r.b.y   = t_pos'(y);
        r.b.s   = {t_str'(d), t_str'(c), t_str'(b), t_str'(a)};
        r.typed = 1'b0;
        r.want  = '0;
        return r;
    endfunction

    function automatic t_row row_typed(int a, int b, int c, int d, int ex, int ey, int slot,
                                       bit found);
        t_row r;
        r = row_beat(OP_QUERY, 0, 0, 0, a, b, c, d);
        r.typed      = 1'b1;
        r.want.x     = t_pos'(ex);
        r.want.y     = t_pos'(ey);
        r.want.slot  = MATCH_W'(slot);
        r.want.found = found;
        return r;
    endfunction

    function automatic t_row row_cfg(int value);
        t_row r;
        r = row_beat(OP_QUERY, 0, 0, 0, 0, 0, 0, 0);
        r.kind = ROW_CFG;
        r.cfg  = CFG_W'(value);
        return r;
    endfunction

    // result side
    t_stall_mode stall_mode;
    int stall_left;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall    <= 1'b0;
            stall_mode <= STALL_NONE;
            stall_left <= 0;
        end else begin
            if (stall_left == 0) begin
                stall_mode <= t_stall_mode'($urandom_range(3));
                stall_left <= $urandom_range(300, 60);
            end else begin
                stall_left <= stall_left - 1;
            end
            case (stall_mode)
                STALL_NONE:    i_stall <= 1'b0;
                STALL_SPARSE:  i_stall <= ($urandom_range(3) == 0);
                STALL_PATTERN: i_stall <= (stall_left[3:0] < 10);
                default:       i_stall <= ($urandom_range(3) != 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_match want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_matches.size() == 0) begin
                report_mismatch("result beat with nothing pending", int'(o_match_slot), -1);
            end else begin
                want = pending_matches.pop_front();
                if (o_est_x !== want.x)
                    report_mismatch("est_x", int'(o_est_x), int'(want.x));
                if (o_est_y !== want.y)
                    report_mismatch("est_y", int'(o_est_y), int'(want.y));
                if (o_match_slot !== want.slot)
                    report_mismatch("match_slot", int'(o_match_slot), int'(want.slot));
                if (o_found !== want.found)
                    report_mismatch("found", int'(o_found), int'(want.found));
            end
        end
    end

    initial begin
        cycles = 0;
        while (cycles < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    initial begin
        t_beat b;
        int round;
        int n_sent;
        int round_len;
        int pick;
        int r;
        int span;
        int low;
        int j;
        logic [CFG_W-1:0] setting;

        errors = 0;
        burst_left = 0;
        entries_shadow = '0;
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_operation   <= 1'b0;
        i_entry_index <= '0;
        i_ref_pos_x   <= '0;
        i_ref_pos_y   <= '0;
        i_strength_a  <= '0;
        i_strength_b  <= '0;
        i_strength_c  <= '0;
        i_strength_d  <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;

        // empty search right after reset, then one entry, then a full table
        add_row(row_typed(0, 0, 0, 0, 0, 0, 0, 1'b0));
        add_row(row_typed(2047, 2047, 2047, 2047, 0, 0, 0, 1'b0));
        add_row(row_beat(OP_LOAD, 0, 32767, -32768, 2047, -2048, 0, 100));
        add_row(row_cfg(1));
        add_row(row_typed(-2048, -2048, -2048, -2048, 32767, -32768, 0, 1'b1));
        add_row(row_typed(2047, -2048, 0, 100, 32767, -32768, 0, 1'b1));
        add_row(row_beat(OP_LOAD, 1, 0, 0, -2048, -2048, -2048, -2048));
        add_row(row_beat(OP_LOAD, 2, 160, -160, -800, -900, -1000, -1100));
        // same strengths as slot 2, so a distance tie goes to slot 2
        add_row(row_beat(OP_LOAD, 3, 321, 322, -800, -900, -1000, -1100));
        add_row(row_beat(OP_LOAD, 4, -1, 1, 2047, 2047, 2047, 2047));
        add_row(row_beat(OP_LOAD, 5, 1000, 2000, -600, -700, -650, -720));
        add_row(row_beat(OP_LOAD, 6, -32768, 32767, 0, 0, 0, 0));
        add_row(row_beat(OP_LOAD, 7, 12345, -12345, 1, -1, 2047, -2048));
        add_row(row_cfg(8));
        add_row(row_beat(OP_QUERY, 0, 0, 0, -600, -700, -650, -720));
        add_row(row_beat(OP_QUERY, 0, 0, 0, -800, -900, -1000, -1100));
        add_row(row_beat(OP_QUERY, 0, 0, 0, 5, 5, 5, 5));
        add_row(row_beat(OP_QUERY, 0, 0, 0, -900, -900, -100, -50));
        add_row(row_beat(OP_QUERY, 0, 0, 0, -2048, -2048, -2048, -2048));
        add_row(row_beat(OP_QUERY, 0, 0, 0, 2047, 2047, 2047, 2047));
        // above the table size the search length saturates
        add_row(row_cfg(15));
        add_row(row_beat(OP_QUERY, 0, 0, 0, 1, -1, 2047, -2048));
        add_row(row_beat(OP_QUERY, 0, 0, 0, 300, -300, 300, -300));
        add_row(row_cfg(0));
        add_row(row_typed(100, 200, 300, 400, 0, 0, 0, 1'b0));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[n]) begin
            if (directed[n].kind == ROW_CFG) begin
                write_entries_in_use(directed[n].cfg);
            end else begin
                send_beat(directed[n].b, directed[n].typed, directed[n].want);
                pace();
            end
        end

        // every slot is loaded by now, so any search length is safe
        n_sent = 0;
        round = 0;
        while (n_sent < RANDOM_BEATS) begin
            case (round)
                0: setting = CFG_W'(8);
                1: setting = CFG_W'(0);
                2: setting = CFG_W'(15);
                3: setting = CFG_W'(1);
                4: setting = CFG_W'(9);
                default: setting = CFG_W'($urandom_range(15));
            endcase
            write_entries_in_use(setting);
            round_len = $urandom_range(120, 40);
            span = searched_entries();
            for (int n = 0; n < round_len; n++) begin
                b.x = rand_pos();
                b.y = rand_pos();
                b.idx = IDX_W'($urandom_range(TABLE_ENTRIES - 1));
                r = (span == 0) ? 0 : $urandom_range(span - 1);
                pick = $urandom_range(9);
                if ($urandom_range(9) < 3) begin
                    b.op = OP_LOAD;
                    for (int k = 0; k < AP_COUNT; k++)
                        b.s[k] = (pick < 3) ? tbl_str[r][k] : rand_str();
                end else begin
                    b.op = OP_QUERY;
                    if (pick < 3) begin
                        // close to an entry in use
                        for (int k = 0; k < AP_COUNT; k++)
                            b.s[k] = t_str'(int'(tbl_str[r][k]) + $urandom_range(16) - 8);
                    end else if (pick < 5) begin
                        for (int k = 0; k < AP_COUNT; k++)
                            b.s[k] = tbl_str[r][k];
                    end else if (pick < 7) begin
                        // tie on the weakest strength
                        low = int'(rand_str());
                        for (int k = 0; k < AP_COUNT; k++)
                            b.s[k] = t_str'(low + $urandom_range(60));
                        j = $urandom_range(AP_COUNT - 1);
                        b.s[j] = t_str'(low);
                        b.s[$urandom_range(AP_COUNT - 1)] = t_str'(low);
                    end else begin
                        for (int k = 0; k < AP_COUNT; k++)
                            b.s[k] = rand_str();
                    end
                end
                send_beat(b, 1'b0, '0);
                pace();
                n_sent++;
            end
            round++;
        end

        drain_results();
        repeat (20) @(posedge i_clk);
        if (errors == 0 && pending_matches.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
